// ===== rtl/grsa_pkg.sv =====
// shared types, constants and tables for the gated residual scale activation block
package grsa_pkg;

  // nonlinear unit: exponent front end plus restoring divider
  localparam int DIV_STEPS = 17;
  localparam int DIV_NW    = 51;
  localparam int DEN_W     = 35;
  localparam int NL_LAT    = 8 + DIV_STEPS;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef enum logic {
    NL_SIGMOID,
    NL_MISH
  } nl_kind_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_RELU,
    ACT_RELU_SQ,
    ACT_TANH,
    ACT_SIGMOID,
    ACT_SELU,
    ACT_SWISH,
    ACT_MISH
  } act_mode_t;

  typedef enum logic [1:0] {
    SH_8,
    SH_16,
    SH_40
  } rsh_t;

  localparam logic CFG_ACT_MODE  = 1'b0;
  localparam logic CFG_PREV_BIAS = 1'b1;

  // 2^(-j/16) in q1.16
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/grsa_nlin.sv =====
// pipelined exp(-|x|) front end with sigmoid or mish ratio divider
module grsa_nlin (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic signed [19:0]  in_x,
  input  grsa_pkg::nl_kind_t  in_kind,
  output logic                out_vld,
  output logic [16:0]         out_q,
  output logic [16:0]         out_e
);
  import grsa_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [19:0] a1_r;
  logic neg1_r, neg2_r, neg3_r, neg4_r, neg5_r, neg6_r;
  nl_kind_t kind1_r, kind2_r, kind3_r, kind4_r, kind5_r, kind6_r;
  logic [28:0] t2_r;
  logic [16:0] base3_r;
  logic [23:0] prod3_r;
  logic [4:0]  nsh3_r, nsh4_r;
  logic        big3_r, big4_r;
  logic [16:0] v4v_r, e5_r, e6_r, e7_r, e8_r;
  logic [33:0] sq6_r;
  logic [DIV_NW-1:0] numf7_r, dvd8_r;
  logic [DEN_W-1:0]  den7_r, den8_r;

  logic [4:0]  idx3;
  logic [16:0] diff3;
  logic [16:0] e5_nxt;
  logic [DEN_W-1:0]  n0_7, den7_nxt;
  logic [DIV_NW-1:0] numf7_nxt;

  logic                vd_r   [DIV_STEPS];
  logic [DIV_NW-1:0]   rem_r  [DIV_STEPS];
  logic [DEN_W-1:0]    dd_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r   [DIV_STEPS];
  logic [16:0]         ed_r   [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r;   v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
    end
  end

  // magnitude, then scale by log2(e)
  always_ff @(posedge clk) begin
    a1_r    <= in_x[19] ? 20'(-in_x) : 20'(in_x);
    neg1_r  <= in_x[19];
    kind1_r <= in_kind;
    t2_r    <= 29'((37'(a1_r) * 37'(LOG2E_Q16) + 37'd128) >> 8);
    neg2_r  <= neg1_r;
    kind2_r <= kind1_r;
  end

  // table interpolation
  always_comb begin
    idx3  = {1'b0, t2_r[15:12]};
    diff3 = pow2_tab(idx3) - pow2_tab(idx3 + 5'd1);
  end

  always_ff @(posedge clk) begin
    base3_r <= pow2_tab(idx3);
    prod3_r <= 24'(diff3[11:0]) * 24'(t2_r[11:0]);
    nsh3_r  <= t2_r[20:16];
    big3_r  <= t2_r[28:16] >= 13'd24;
    neg3_r  <= neg2_r;
    kind3_r <= kind2_r;
    v4v_r   <= base3_r - 17'((25'(prod3_r) + 25'd2048) >> 12);
    nsh4_r  <= nsh3_r;
    big4_r  <= big3_r;
    neg4_r  <= neg3_r;
    kind4_r <= kind3_r;
  end

  // integer part of the exponent as a rounded right shift
  always_comb begin
    if (big4_r) begin
      e5_nxt = '0;
    end else if (nsh4_r == 5'd0) begin
      e5_nxt = v4v_r;
    end else begin
      e5_nxt = 17'(({7'b0, v4v_r} + (24'd1 << (nsh4_r - 5'd1))) >> nsh4_r);
    end
  end

  always_ff @(posedge clk) begin
    e5_r    <= e5_nxt;
    neg5_r  <= neg4_r;
    kind5_r <= kind4_r;
    sq6_r   <= 34'(e5_r) * 34'(e5_r);
    e6_r    <= e5_r;
    neg6_r  <= neg5_r;
    kind6_r <= kind5_r;
  end

  // numerator and denominator of the ratio
  always_comb begin
    n0_7 = '0;
    case (kind6_r)
      NL_MISH: begin
        if (neg6_r) begin
          n0_7     = 35'(sq6_r) + (35'(e6_r) << 17);
          den7_nxt = n0_7 + (35'd1 << 33);
        end else begin
          n0_7     = (35'd1 << 32) + (35'(e6_r) << 17);
          den7_nxt = n0_7 + (35'(sq6_r) << 1);
        end
        numf7_nxt = 51'(n0_7) << 16;
      end
      default: begin
        den7_nxt  = 35'(e6_r) + 35'd65536;
        numf7_nxt = neg6_r ? (51'(e6_r) << 16) : (51'd1 << 32);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    numf7_r <= numf7_nxt;
    den7_r  <= den7_nxt;
    e7_r    <= e6_r;
    dvd8_r  <= numf7_r + 51'(den7_r >> 1);
    den8_r  <= den7_r;
    e8_r    <= e7_r;
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - j;
    logic                 v_in;
    logic [DIV_NW-1:0]    rem_in;
    logic [DEN_W-1:0]     den_in;
    logic [DIV_STEPS-1:0] q_in;
    logic [16:0]          e_in;
    logic [DIV_NW:0]      dsh;
    logic                 ge;

    if (j == 0) begin : g_first
      assign v_in   = v8_r;
      assign rem_in = dvd8_r;
      assign den_in = den8_r;
      assign q_in   = '0;
      assign e_in   = e8_r;
    end else begin : g_next
      assign v_in   = vd_r[j-1];
      assign rem_in = rem_r[j-1];
      assign den_in = dd_r[j-1];
      assign q_in   = q_r[j-1];
      assign e_in   = ed_r[j-1];
    end

    assign dsh = {{(DIV_NW + 1 - DEN_W){1'b0}}, den_in} << SH;
    assign ge  = {1'b0, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j] <= 1'b0;
      end else begin
        vd_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? DIV_NW'({1'b0, rem_in} - dsh) : rem_in;
      dd_r[j]  <= den_in;
      q_r[j]   <= q_in | (ge ? (DIV_STEPS'(1) << SH) : '0);
      ed_r[j]  <= e_in;
    end
  end

  assign out_vld = vd_r[DIV_STEPS-1];
  assign out_q   = q_r[DIV_STEPS-1];
  assign out_e   = ed_r[DIV_STEPS-1];

endmodule

// ===== rtl/gated_residual_scale_activation.sv =====
// top level: gated residual sum with selectable q8.8 activation
// One item is taken in every clock cycle (start is never refused, busy stays low) and
// its result appears on out_result_value with out_valid high for one cycle. Items leave
// in the order they came. The result port cannot be held off, so a result must be taken
// in the cycle it is shown. Most of the pipeline is two passes through a 25-stage
// nonlinear unit (exponent lookup followed by a 17-stage bit-per-stage divider): one
// for the gate sigmoid, one for the output activation. Registers are written through
// cfg_we/cfg_index/cfg_wdata and must only change while no item is in flight.
module gated_residual_scale_activation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_residual_value,
  input  logic signed [15:0] in_skip_value,
  input  logic signed [15:0] in_gate_raw,
  input  logic signed [15:0] in_shift_bias,
  input  logic signed [15:0] in_prev_bias,
  output logic               out_valid,
  output logic signed [15:0] out_result_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_wdata
);
  import grsa_pkg::*;

  localparam logic signed [34:0] SELU_LAMBDA = 35'sd68858;
  // lambda * alpha in q32
  localparam logic signed [34:0] SELU_LA     = 35'sd7550899422;

  typedef struct packed {
    logic signed [16:0] r;
    logic signed [15:0] skip;
    logic signed [15:0] shift;
  } side_a_t;

  // configuration
  act_mode_t mode_r;
  logic      bias_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ACT_NONE;
      bias_on_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACT_MODE:  mode_r    <= act_mode_t'(cfg_wdata);
        CFG_PREV_BIAS: bias_on_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // never stalls
  assign busy = 1'b0;

  // stage 1: input capture, optional previous bias
  logic               v1_r;
  logic signed [16:0] r1_r;
  logic signed [15:0] skip1_r, shift1_r, gate1_r;
  logic signed [16:0] r1_nxt;

  always_comb begin
    r1_nxt = 17'(in_residual_value) + (bias_on_r ? 17'(in_prev_bias) : 17'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    r1_r     <= r1_nxt;
    skip1_r  <= in_skip_value;
    shift1_r <= in_shift_bias;
    gate1_r  <= in_gate_raw;
  end

  // gate sigmoid
  logic        va;
  logic [16:0] qa, ea;

  grsa_nlin u_gate (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v1_r),
    .in_x    (20'(gate1_r)),
    .in_kind (NL_SIGMOID),
    .out_vld (va),
    .out_q   (qa),
    .out_e   (ea)
  );

  // side data waits alongside the gate unit
  side_a_t sa_r [NL_LAT];

  always_ff @(posedge clk) begin
    sa_r[0] <= '{r: r1_r, skip: skip1_r, shift: shift1_r};
    for (int i = 1; i < NL_LAT; i++) begin
      sa_r[i] <= sa_r[i-1];
    end
  end

  // stages 2..4: residual times gate, rounded, plus skip and shift
  logic               v2_r, v3_r, v4_r;
  logic signed [34:0] prod2_r;
  logic signed [15:0] skip2_r, shift2_r, skip3_r, shift3_r;
  logic signed [18:0] m3_r, op4_r;
  logic [34:0]        mag2;
  logic [34:0]        rm2;

  always_comb begin
    mag2 = prod2_r[34] ? 35'(-prod2_r) : 35'(prod2_r);
    rm2  = (mag2 + 35'd32768) >> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= va;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    prod2_r  <= sa_r[NL_LAT-1].r * $signed({1'b0, qa});
    skip2_r  <= sa_r[NL_LAT-1].skip;
    shift2_r <= sa_r[NL_LAT-1].shift;
    m3_r     <= prod2_r[34] ? -$signed(19'(rm2)) : $signed(19'(rm2));
    skip3_r  <= skip2_r;
    shift3_r <= shift2_r;
    op4_r    <= m3_r + 19'(skip3_r) + 19'(shift3_r);
  end

  // activation nonlinearity: tanh runs sigmoid at twice the argument
  logic               vb;
  logic [16:0]        qb, eb;
  logic signed [19:0] xb;
  nl_kind_t           kb;

  always_comb begin
    xb = (mode_r == ACT_TANH) ? {op4_r, 1'b0} : 20'(op4_r);
    kb = (mode_r == ACT_MISH) ? NL_MISH : NL_SIGMOID;
  end

  grsa_nlin u_act (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v4_r),
    .in_x    (xb),
    .in_kind (kb),
    .out_vld (vb),
    .out_q   (qb),
    .out_e   (eb)
  );

  logic signed [18:0] sb_r [NL_LAT];

  always_ff @(posedge clk) begin
    sb_r[0] <= op4_r;
    for (int i = 1; i < NL_LAT; i++) begin
      sb_r[i] <= sb_r[i-1];
    end
  end

  // stage 5: one shared multiplier, or a direct result for the simple modes
  logic               v5_r;
  logic signed [53:0] p5_r;
  rsh_t               sh5_r;
  logic               mul5_r;
  logic signed [18:0] dir5_r;

  logic signed [18:0] opb, mul_a, dir5_nxt, tq;
  logic signed [34:0] mul_b;
  rsh_t               sh5_nxt;
  logic               mul5_nxt;
  logic [18:0]        tmag, trnd;
  logic [17:0]        srnd;

  always_comb begin
    opb      = sb_r[NL_LAT-1];
    mul_a    = '0;
    mul_b    = '0;
    sh5_nxt  = SH_16;
    mul5_nxt = 1'b0;
    dir5_nxt = opb;
    tq       = $signed({1'b0, qb, 1'b0}) - 19'sd65536;
    tmag     = tq[18] ? 19'(-tq) : 19'(tq);
    trnd     = (tmag + 19'd128) >> 8;
    srnd     = (18'(qb) + 18'd128) >> 8;
    case (mode_r)
      ACT_RELU: begin
        dir5_nxt = opb[18] ? 19'sd0 : opb;
      end
      ACT_RELU_SQ: begin
        mul5_nxt = 1'b1;
        sh5_nxt  = SH_8;
        mul_a    = opb[18] ? 19'sd0 : opb;
        mul_b    = 35'(opb);
      end
      ACT_TANH: begin
        dir5_nxt = tq[18] ? -$signed(trnd) : $signed(trnd);
      end
      ACT_SIGMOID: begin
        dir5_nxt = $signed(19'(srnd));
      end
      ACT_SELU: begin
        mul5_nxt = 1'b1;
        if (opb[18]) begin
          // negative side: lambda * alpha * (exp(x) - 1)
          sh5_nxt = SH_40;
          mul_a   = $signed({2'b0, eb}) - 19'sd65536;
          mul_b   = SELU_LA;
        end else begin
          sh5_nxt = SH_16;
          mul_a   = opb;
          mul_b   = SELU_LAMBDA;
        end
      end
      ACT_SWISH, ACT_MISH: begin
        mul5_nxt = 1'b1;
        mul_a    = opb;
        mul_b    = $signed({18'b0, qb});
      end
      default: begin
        dir5_nxt = opb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= vb;
    end
  end

  always_ff @(posedge clk) begin
    p5_r   <= mul_a * mul_b;
    sh5_r  <= sh5_nxt;
    mul5_r <= mul5_nxt;
    dir5_r <= dir5_nxt;
  end

  // stage 6: round the product half away from zero, or pass the direct result
  logic               v6_r;
  logic signed [46:0] val6_r;
  logic [53:0]        pmag;
  logic [53:0]        prnd;
  logic signed [46:0] val6_nxt;

  always_comb begin
    pmag = p5_r[53] ? 54'(-p5_r) : 54'(p5_r);
    case (sh5_r)
      SH_8:    prnd = (pmag + (54'd1 << 7)) >> 8;
      SH_40:   prnd = (pmag + (54'd1 << 39)) >> 40;
      default: prnd = (pmag + (54'd1 << 15)) >> 16;
    endcase
    if (mul5_r) begin
      val6_nxt = p5_r[53] ? -$signed(47'(prnd)) : $signed(47'(prnd));
    end else begin
      val6_nxt = 47'(dir5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    val6_r <= val6_nxt;
  end

  // stage 7: saturate into the output register
  logic               out_valid_r;
  logic signed [15:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (val6_r > 47'sd32767) begin
      out_value_r <= 16'sd32767;
    end else if (val6_r < -47'sd32768) begin
      out_value_r <= -16'sd32768;
    end else begin
      out_value_r <= val6_r[15:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

endmodule

// ===== tb/tb_top.sv =====
// testbench for gated_residual_scale_activation: predicted results checked item by item
module tb_top;
  import grsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // prediction of the gated q8.8 sum and its activation, plus the store of expected values
  class act_result_board;
    act_mode_t mode;
    bit bias_on;
    logic signed [15:0] pending_values[$];
    int errors;

    // 2^(-j/16) in q1.16
    longint pow2_neg[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
                             44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    function new();
      mode = ACT_NONE;
      bias_on = 1'b0;
      errors = 0;
    endfunction

    function longint round_shift(longint v, int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
    endfunction

    // exp(-a) in q1.16, a >= 0 in q8.8
    function longint exp_neg(longint a);
      longint t, n, g, idx, fr, v;
      t = (a * 94548 + 128) >>> 8;
      n = t >>> 16;
      g = t & 65535;
      idx = g >>> 12;
      fr = g & 4095;
      if (n >= 24) return 0;
      v = pow2_neg[idx] - (((pow2_neg[idx] - pow2_neg[idx + 1]) * fr + 2048) >>> 12);
      if (n == 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint sigmoid_q16(longint x);
      longint e, den, num;
      e = exp_neg((x < 0) ? -x : x);
      den = 65536 + e;
      num = (x >= 0) ? (64'sd1 <<< 32) : e * 65536;
      return (num + den / 2) / den;
    endfunction

    // tanh(softplus(x)) in q1.16
    function longint mish_ratio(longint x);
      longint u, num, den;
      if (x >= 0) begin
        u = exp_neg(x);
        num = (64'sd1 <<< 32) + 2 * u * 65536;
        den = num + 2 * u * u;
      end else begin
        u = exp_neg(-x);
        num = u * u + 2 * u * 65536;
        den = num + (64'sd1 <<< 33);
      end
      return (num * 65536 + den / 2) / den;
    endfunction

    function longint activate(longint x);
      case (mode)
        ACT_RELU:    return (x < 0) ? 0 : x;
        ACT_RELU_SQ: return (x < 0) ? 0 : round_shift(x * x, 8);
        ACT_TANH:    return round_shift(2 * sigmoid_q16(2 * x) - 65536, 8);
        ACT_SIGMOID: return round_shift(sigmoid_q16(x), 8);
        ACT_SELU: begin
          if (x >= 0) return round_shift(x * 68858, 16);
          return round_shift(longint'(68858) * 109659 * (exp_neg(-x) - 65536), 40);
        end
        ACT_SWISH:   return round_shift(x * sigmoid_q16(x), 16);
        ACT_MISH:    return round_shift(x * mish_ratio(x), 16);
        default:     return x;
      endcase
    endfunction

    function void note_item(logic signed [15:0] res, logic signed [15:0] skip,
                            logic signed [15:0] gate, logic signed [15:0] shift,
                            logic signed [15:0] prev);
      longint r, sum, y;
      r = res;
      if (bias_on) r = r + prev;
      sum = round_shift(r * sigmoid_q16(gate), 16) + skip + shift;
      y = activate(sum);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      pending_values.push_back(y[15:0]);
    endfunction

    function void check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending_values.size() == 0) begin
        $error("result_value: expected none, got %0d", got);
        errors++;
        return;
      end
      want = pending_values.pop_front();
      if (got !== want) begin
        $error("result_value: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_residual_value = '0;
  logic signed [15:0] in_skip_value = '0;
  logic signed [15:0] in_gate_raw = '0;
  logic signed [15:0] in_shift_bias = '0;
  logic signed [15:0] in_prev_bias = '0;
  logic out_valid;
  logic signed [15:0] out_result_value;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [2:0] cfg_wdata = '0;

  act_result_board board = new();
  bit took;          // set by the monitor when the current item is accepted
  bit idling_on = 1'b1;

  gated_residual_scale_activation uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: sample handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.note_item(in_residual_value, in_skip_value, in_gate_raw, in_shift_bias,
                      in_prev_bias);
      took = 1'b1;
    end
    if (rst_n && out_valid) board.check_result(out_result_value);
  end

  // one item; called and returns at a falling edge
  task automatic send_item(logic signed [15:0] res, logic signed [15:0] skip,
                           logic signed [15:0] gate, logic signed [15:0] shift,
                           logic signed [15:0] prev);
    while (idling_on && $urandom_range(99) < 23) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_residual_value = res;
    in_skip_value = skip;
    in_gate_raw = gate;
    in_shift_bias = shift;
    in_prev_bias = prev;
    start = 1'b1;
    took = 1'b0;
    do @(negedge clk); while (!took);
  endtask

  // let everything in flight drain, with a few spare cycles
  task automatic drain();
    start = 1'b0;
    while (board.pending_values.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_ACT_MODE) board.mode = act_mode_t'(val);
    else board.bias_on = val[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // random field: full range or small magnitude near the interesting region
  function automatic logic signed [15:0] pick_val();
    case ($urandom_range(3))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(2047) - 1024);
      default: return 16'($urandom_range(8191) - 4096);
    endcase
  endfunction

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    // walk every activation with the bias off and on; extremes come first
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      write_reg(CFG_ACT_MODE, ph[3:1]);
      write_reg(CFG_PREV_BIAS, {2'b00, ph[0]});
      // long stretch with no idling
      idling_on = !(ph == 6 || ph == 7);
      // directed: all max, all min, zeros, gate saturated both ways, opposite extremes
      send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
      send_item('0, '0, '0, '0, '0);
      send_item(16'sh0100, '0, -16'sh8000, '0, 16'sh0100);
      send_item(16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh0000, -16'sh8000);
      send_item(16'sh0080, 16'sh0040, 16'sh0200, -16'sh0100, 16'sh0400);
      for (int i = 0; i < 108; i++)
        send_item(pick_val(), pick_val(), pick_val(), pick_val(), pick_val());
    end
    drain();
    repeat (70) @(negedge clk);
    if (board.errors == 0 && board.pending_values.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/grsa_pkg.sv
rtl/grsa_nlin.sv
rtl/gated_residual_scale_activation.sv
tb/tb_top.sv
